FILE: rtl/sews_pkg.sv
// ----------------------------------------------------------------------------
// sews_pkg: shared types and constants for the serial word store
// Command codes, controller states and the factory image of the word array.
// ----------------------------------------------------------------------------
package sews_pkg;

    typedef enum logic [2:0] {
        CMD_DATA_IN   = 3'b000,
        CMD_ADDR_IN   = 3'b001,
        CMD_SHIFT_OUT = 3'b010,
        CMD_UNUSED    = 3'b011,
        CMD_WRITE     = 3'b100,
        CMD_ERASE     = 3'b101,
        CMD_READ      = 3'b110,
        CMD_STANDBY   = 3'b111
    } t_cmd;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_LOAD = 1'b1
    } t_state;

    localparam logic [31:0] ADDR_RESET_VALUE = 32'h0000_ffff;
    localparam logic [15:0] FACTORY_FILL     = 16'h2e80;
    localparam int unsigned FACTORY_FILL_END = 39;

    // Factory contents of one word, before masking to the word width
    function automatic logic [15:0] f_factory(input logic [7:0] idx);
        logic [15:0] w;
        if (idx < 8'(FACTORY_FILL_END)) begin
            w = FACTORY_FILL;
        end else begin
            case (idx)
                8'd39:   w = 16'h2e00;
                8'd40:   w = 16'h2e08;
                8'd41:   w = 16'h2e8e;
                8'd42:   w = 16'h2e00;
                8'd43:   w = 16'h2e50;
                8'd44:   w = 16'h2e30;
                8'd45:   w = 16'h2e40;
                8'd46:   w = 16'h2e20;
                8'd47:   w = 16'h2e00;
                8'd48:   w = 16'h2ee0;
                8'd49:   w = 16'h2ee0;
                8'd50:   w = 16'h2e51;
                default: w = 16'h0000;
            endcase
        end
        return w;
    endfunction

endpackage

FILE: rtl/sews_store.sv
// ----------------------------------------------------------------------------
// sews_store: word array with per-word valid bits
// A word never written since reset reads back its factory value.
// Read data is registered; one write and one read per cycle.
// ----------------------------------------------------------------------------
module sews_store
    import sews_pkg::*;
#(
    parameter int WORDS     = 100,
    parameter int WORD_BITS = 14
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic [$clog2(WORDS)-1:0] i_wr_addr,
    input  logic [WORD_BITS-1:0]     i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(WORDS)-1:0] i_rd_addr,
    output logic [WORD_BITS-1:0]     o_rd_data
);

    logic [WORD_BITS-1:0] r_mem [WORDS];
    logic [WORDS-1:0]     r_valid;
    logic [WORD_BITS-1:0] r_rd_mem;
    logic [WORD_BITS-1:0] r_rd_fact;
    logic                 r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_mem  <= r_mem[i_rd_addr];
            r_rd_fact <= WORD_BITS'(f_factory(8'(i_rd_addr)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_mem : r_rd_fact;

endmodule

FILE: rtl/serial_earom_word_store.sv
// ----------------------------------------------------------------------------
// serial_earom_word_store: serial nonvolatile-style word store
// Grid of GRID_SIDE x GRID_SIDE words, addressed through a serial shift
// register and loaded or unloaded one bit per command through a data
// shift register.
//
//   channel   dir  tdata                          tuser
//   s (cmd)   in   [0] data_in, [1] rising_edge   [2:0] operation
//   m (bit)   out  [0] data_out                   -
//
// One command per cycle while ready; a read command moves the block to ST_LOAD,
// where it takes no command and loads the registered word from the store into
// the data register. Reset is synchronous and clears the word valid bits at
// once, so no sweep follows it. A stalled output holds its bit and blocks
// further commands only while the result register is full and not taken.
// ----------------------------------------------------------------------------
module serial_earom_word_store
    import sews_pkg::*;
#(
    parameter int GRID_SIDE = 10,
    parameter int WORD_BITS = 14
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [0] data_in, [1] rising_edge
    input  logic [2:0] i_s_tuser,   // [2:0] operation
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [0] data_out
);

    localparam int WORDS  = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = 2 * GRID_SIDE;
    localparam int IDX_W  = $clog2(WORDS);
    localparam int DIG_W  = $clog2(GRID_SIDE);
    localparam logic [ADDR_W-1:0] ADDR_RESET = ADDR_W'(ADDR_RESET_VALUE);

    // Highest set bit at position p gives GRID_SIDE-1-p; no set bit gives 0
    function automatic logic [DIG_W-1:0] f_digit(input logic [GRID_SIDE-1:0] grp);
        logic [DIG_W-1:0] d;
        d = '0;
        for (int p = 0; p < GRID_SIDE; p++) begin
            if (grp[p]) begin
                d = DIG_W'(GRID_SIDE - 1 - p);
            end
        end
        return d;
    endfunction

    function automatic logic [IDX_W-1:0] f_index(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] inv;
        logic [DIG_W-1:0]  tens;
        logic [DIG_W-1:0]  ones;
        inv  = ~addr;
        tens = f_digit(inv[GRID_SIDE-1:0]);
        ones = f_digit(inv[ADDR_W-1:GRID_SIDE]);
        return IDX_W'(IDX_W'(tens) * IDX_W'(GRID_SIDE) + IDX_W'(ones));
    endfunction

    t_state               r_state, n_state;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic [IDX_W-1:0]     r_index;
    logic [WORD_BITS-1:0] r_data, n_data;
    logic                 r_serial, n_serial;
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_data, n_out_data;

    logic                 accept;
    logic                 act;
    t_cmd                 cmd;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [WORD_BITS-1:0] rd_data;

    sews_store #(
        .WORDS     (WORDS),
        .WORD_BITS (WORD_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_index),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_index),
        .o_rd_data (rd_data)
    );

    always_comb begin
        cmd         = t_cmd'(i_s_tuser);
        o_s_tready  = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
        accept      = i_s_tvalid && o_s_tready;
        act         = accept && i_s_tdata[1];
        n_state     = r_state;
        n_addr      = r_addr;
        n_data      = r_data;
        n_serial    = r_serial;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        wr_en       = 1'b0;
        wr_data     = r_data;
        rd_en       = 1'b0;

        if (r_state == ST_LOAD) begin
            n_data  = rd_data;
            n_state = ST_IDLE;
        end

        if (act) begin
            case (cmd)
                CMD_ADDR_IN: begin
                    n_addr = {r_addr[ADDR_W-2:0], i_s_tdata[0]};
                end
                CMD_DATA_IN: begin
                    n_data = {r_data[WORD_BITS-2:0], i_s_tdata[0]};
                end
                CMD_ERASE: begin
                    wr_en   = 1'b1;
                    wr_data = '1;
                end
                CMD_WRITE: begin
                    wr_en = 1'b1;
                end
                CMD_READ: begin
                    rd_en   = 1'b1;
                    n_state = ST_LOAD;
                end
                CMD_SHIFT_OUT: begin
                    n_serial = r_data[WORD_BITS-1];
                    n_data   = {r_data[WORD_BITS-2:0], 1'b0};
                end
                default: begin
                end
            endcase
        end

        // Present the serial bit for every accepted transaction
        if (accept) begin
            n_out_valid = 1'b1;
            n_out_data  = n_serial;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_addr      <= ADDR_RESET;
            r_index     <= f_index(ADDR_RESET);
            r_data      <= '0;
            r_serial    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_index     <= f_index(n_addr);
            r_data      <= n_data;
            r_serial    <= n_serial;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_out_data};

endmodule

FILE: rtl/sews_port_check.sv
// ----------------------------------------------------------------------------
// sews_port_check: port-level checks for the serial word store
// Watches the command and bit channels and is bound to the top level.
// ----------------------------------------------------------------------------
module sews_port_check
    import sews_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic [7:0] i_s_tdata,
    input logic [2:0] i_s_tuser,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata
);

    logic s_acc;
    assign s_acc = i_s_tvalid && o_s_tready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output changed while stalled");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> o_m_tvalid)
        else $error("accepted command produced no result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(s_acc))
        else $error("result without a command");

    a_read_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && i_s_tdata[1] && (i_s_tuser == CMD_READ) |=> !o_s_tready)
        else $error("read did not hold off the next command");

    a_idle_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && !i_s_tdata[1] && o_m_tvalid |=> o_m_tdata[0] == $past(o_m_tdata[0]))
        else $error("serial bit changed without an edge");

endmodule

bind serial_earom_word_store sews_port_check u_port_check (.*);
